// ===== hdl/evr_pkg.sv =====
// ----------------------------------------------------------------------------
// evr_pkg
// Shared types, constants and tables for the Euler ZYX vector rotator.
// ----------------------------------------------------------------------------
package evr_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_COUNT       = 24;
  localparam int ANG_FULL         = 23040;
  localparam int GAIN_Q30         = 652032874;
  localparam int MID_DEPTH        = 4;
  localparam int OUT_DEPTH        = 2;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
  } out_t;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
  } vecacc_t;

  typedef struct packed {
    vecacc_t                  va;
    logic [2:0]               flip;
    logic [2:0][31:0]         phase;
  } work_t;

  typedef logic [22:0] frac_tab_t [64];

  function automatic frac_tab_t frac_table();
    frac_tab_t t;
    longint v;
    for (int m = 0; m < 64; m++) begin
      v = ((longint'(m) <<< 23) + 22) / 45;
      t[m] = (m < 45) ? v[22:0] : 23'd0;
    end
    return t;
  endfunction

  function automatic logic [29:0] atan_turn(input int i);
    logic [29:0] r;
    case (i)
      0:  r = 30'd536870912;
      1:  r = 30'd316933406;
      2:  r = 30'd167458907;
      3:  r = 30'd85004756;
      4:  r = 30'd42667331;
      5:  r = 30'd21354465;
      6:  r = 30'd10679838;
      7:  r = 30'd5340245;
      8:  r = 30'd2670163;
      9:  r = 30'd1335087;
      10: r = 30'd667544;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41722;
      15: r = 30'd20861;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2608;
      19: r = 30'd1304;
      20: r = 30'd652;
      21: r = 30'd326;
      22: r = 30'd163;
      23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/evr_fifo.sv =====
// ----------------------------------------------------------------------------
// evr_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module evr_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T               mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/evr_front.sv =====
// ----------------------------------------------------------------------------
// evr_front
// Angle reduction to a 32-bit binary phase and quadrant fold, three stages.
// ----------------------------------------------------------------------------
module evr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          load,
  input  evr_pkg::in_t  item,
  output logic          out_valid,
  output evr_pkg::work_t out_work
);

  localparam evr_pkg::frac_tab_t FRAC = evr_pkg::frac_table();
  localparam int RECIP = 23302;

  logic              v1, v2;
  evr_pkg::vecacc_t  va1, va2;
  logic [2:0][14:0]  r1, r2;
  logic [2:0][8:0]   q2;
  logic [2:0][14:0]  r_next;
  logic [2:0][8:0]   q_next;
  logic [2:0][31:0]  ph_next;
  logic [2:0]        fl_next;

  always_comb begin
    logic signed [15:0] a [3];
    logic signed [17:0] a1, a2;
    logic [29:0]        prod;
    logic [14:0]        m;
    logic [31:0]        ph, ph_off;
    a[0] = item.roll_angle;
    a[1] = item.pitch_angle;
    a[2] = item.yaw_angle;
    for (int l = 0; l < 3; l++) begin
      a1 = (a[l] < 0) ? 18'(a[l]) + 18'sd23040 : 18'(a[l]);
      if (a1 < 0) begin
        a2 = a1 + 18'sd23040;
      end else if (a1 >= 18'sd23040) begin
        a2 = a1 - 18'sd23040;
      end else begin
        a2 = a1;
      end
      r_next[l] = a2[14:0];
      prod      = 30'(r1[l]) * 30'(RECIP);
      q_next[l] = prod[28:20];
      m         = r2[l] - 15'(q2[l] * 15'd45);
      ph        = {q2[l], FRAC[m[5:0]]};
      ph_off    = ph + 32'h4000_0000;
      fl_next[l] = ph_off[31];
      ph_next[l] = ph_off[31] ? (ph ^ 32'h8000_0000) : ph;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      va1 <= '{vec_x: item.vec_x, vec_y: item.vec_y, vec_z: item.vec_z,
               acc_x: item.acc_x, acc_y: item.acc_y, acc_z: item.acc_z};
      r1  <= r_next;
      va2 <= va1;
      r2  <= r1;
      q2  <= q_next;
      out_work.va    <= va2;
      out_work.flip  <= fl_next;
      out_work.phase <= ph_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= load;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

// ===== hdl/evr_back.sv =====
// ----------------------------------------------------------------------------
// evr_back
// Pipelined CORDIC for three angles, rotation matrix, product and sum.
// ----------------------------------------------------------------------------
module evr_back #(
  parameter int CORDIC_STEPS = evr_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           load,
  input  evr_pkg::work_t work,
  output logic           res_valid,
  output evr_pkg::out_t  res
);

  localparam int N = (CORDIC_STEPS < evr_pkg::ATAN_COUNT) ?
                     CORDIC_STEPS : evr_pkg::ATAN_COUNT;

  logic signed [33:0] cx [N+1][3];
  logic signed [33:0] cy [N+1][3];
  logic signed [33:0] cz [N+1][3];
  logic               cv [N+1];
  evr_pkg::vecacc_t   cva [N+1];
  logic [2:0]         cfl [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        cx[0][l] <= 34'sd652032874;
        cy[0][l] <= '0;
        cz[0][l] <= 34'($signed(work.phase[l]));
      end
      cva[0] <= work.va;
      cfl[0] <= work.flip;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [33:0] ATN = $signed({4'b0, evr_pkg::atan_turn(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (cz[i][l] >= 0) begin
            cx[i+1][l] <= cx[i][l] - (cy[i][l] >>> i);
            cy[i+1][l] <= cy[i][l] + (cx[i][l] >>> i);
            cz[i+1][l] <= cz[i][l] - ATN;
          end else begin
            cx[i+1][l] <= cx[i][l] + (cy[i][l] >>> i);
            cy[i+1][l] <= cy[i][l] - (cx[i][l] >>> i);
            cz[i+1][l] <= cz[i][l] + ATN;
          end
        end
        cva[i+1] <= cva[i];
        cfl[i+1] <= cfl[i];
      end
    end
  end

  // round to Q1.16, clamp, unfold
  logic signed [17:0] sn [3];
  logic signed [17:0] cs [3];
  logic signed [17:0] sn_next [3];
  logic signed [17:0] cs_next [3];
  evr_pkg::vecacc_t   vr;

  always_comb begin
    logic signed [33:0] tc, ts;
    logic signed [17:0] qc, qs;
    for (int l = 0; l < 3; l++) begin
      tc = (cx[N][l] + 34'sd8192) >>> 14;
      ts = (cy[N][l] + 34'sd8192) >>> 14;
      qc = (tc > 34'sd65536) ? 18'sd65536 : (tc < -34'sd65536) ? -18'sd65536 : tc[17:0];
      qs = (ts > 34'sd65536) ? 18'sd65536 : (ts < -34'sd65536) ? -18'sd65536 : ts[17:0];
      cs_next[l] = cfl[N][l] ? -qc : qc;
      sn_next[l] = cfl[N][l] ? -qs : qs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn <= sn_next;
      cs <= cs_next;
      vr <= cva[N];
    end
  end

  // pair products
  logic signed [35:0] cycp, cysp, sycr, sysr, sycp, sysp, cycr, cysr, cpsr, cpcr;
  logic signed [17:0] a_sr, a_cr, a_sp;
  evr_pkg::vecacc_t   vaa;

  always_ff @(posedge clk) begin
    if (en) begin
      cycp <= 36'(cs[2]) * 36'(cs[1]);
      cysp <= 36'(cs[2]) * 36'(sn[1]);
      sycr <= 36'(sn[2]) * 36'(cs[0]);
      sysr <= 36'(sn[2]) * 36'(sn[0]);
      sycp <= 36'(sn[2]) * 36'(cs[1]);
      sysp <= 36'(sn[2]) * 36'(sn[1]);
      cycr <= 36'(cs[2]) * 36'(cs[0]);
      cysr <= 36'(cs[2]) * 36'(sn[0]);
      cpsr <= 36'(cs[1]) * 36'(sn[0]);
      cpcr <= 36'(cs[1]) * 36'(cs[0]);
      a_sr <= sn[0];
      a_cr <= cs[0];
      a_sp <= sn[1];
      vaa  <= vr;
    end
  end

  // matrix entries at scale 2^48
  logic signed [55:0] e [3][3];
  evr_pkg::vecacc_t   vab;

  always_ff @(posedge clk) begin
    if (en) begin
      e[0][0] <= 56'(cycp) <<< 16;
      e[0][1] <= 56'(cysp) * 56'(a_sr) - (56'(sycr) <<< 16);
      e[0][2] <= 56'(cysp) * 56'(a_cr) + (56'(sysr) <<< 16);
      e[1][0] <= 56'(sycp) <<< 16;
      e[1][1] <= 56'(sysp) * 56'(a_sr) + (56'(cycr) <<< 16);
      e[1][2] <= 56'(sysp) * 56'(a_cr) - (56'(cysr) <<< 16);
      e[2][0] <= -(56'(a_sp) <<< 32);
      e[2][1] <= 56'(cpsr) <<< 16;
      e[2][2] <= 56'(cpcr) <<< 16;
      vab     <= vaa;
    end
  end

  // round entries to Q1.16
  logic signed [19:0] m [3][3];
  evr_pkg::vecacc_t   vac;

  always_ff @(posedge clk) begin
    logic signed [55:0] t;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          t = e[k][j] + 56'sd2147483648;
          m[k][j] <= t[51:32];
        end
      end
      vac <= vab;
    end
  end

  // entry times vector
  logic signed [51:0] p [3][3];
  logic signed [31:0] accd [3];

  always_ff @(posedge clk) begin
    logic signed [31:0] v [3];
    v[0] = vac.vec_x;
    v[1] = vac.vec_y;
    v[2] = vac.vec_z;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          p[k][j] <= 52'(m[k][j]) * 52'(v[j]);
        end
      end
      accd[0] <= vac.acc_x;
      accd[1] <= vac.acc_y;
      accd[2] <= vac.acc_z;
    end
  end

  // row sums rounded to Q16.16
  logic signed [37:0] rs [3];
  logic signed [31:0] acce [3];

  always_ff @(posedge clk) begin
    logic signed [53:0] s;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s = 54'(p[k][0]) + 54'(p[k][1]) + 54'(p[k][2]) + 54'sd32768;
        rs[k] <= s[53:16];
      end
      acce <= accd;
    end
  end

  // add accumulator, saturate
  always_comb begin
    logic signed [38:0] t;
    logic signed [31:0] o [3];
    for (int k = 0; k < 3; k++) begin
      t = 39'(rs[k]) + 39'(acce[k]);
      if (t > 39'sd2147483647) begin
        o[k] = 32'sh7FFF_FFFF;
      end else if (t < -39'sd2147483648) begin
        o[k] = 32'sh8000_0000;
      end else begin
        o[k] = t[31:0];
      end
    end
    res.res_x = o[0];
    res.res_y = o[1];
    res.res_z = o[2];
  end

  logic vr_v, va_v, vb_v, vc_v, vd_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N; i++) begin
        cv[i] <= 1'b0;
      end
      vr_v      <= 1'b0;
      va_v      <= 1'b0;
      vb_v      <= 1'b0;
      vc_v      <= 1'b0;
      vd_v      <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      cv[0] <= load;
      for (int i = 0; i < N; i++) begin
        cv[i+1] <= cv[i];
      end
      vr_v      <= cv[N];
      va_v      <= vr_v;
      vb_v      <= va_v;
      vc_v      <= vb_v;
      vd_v      <= vc_v;
      res_valid <= vd_v;
    end
  end

endmodule

// ===== hdl/euler_zyx_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// euler_zyx_vector_rotate
// Rotates a vector by ZYX Euler angles and adds an accumulator.
// ----------------------------------------------------------------------------
// Input channel: push/full carries vector, accumulator and three angles in
// 1/64 degree. Result channel: empty/pop carries the saturated Q16.16 sum.
// The front pipeline reduces each angle to a folded binary phase
// and writes a 4-entry queue. The back pipeline reads that queue and runs a
// CORDIC with one stage per iteration for all three angles in parallel, then
// six stages of matrix build, products and sums, into a 2-entry result queue.
// One item is accepted every cycle while results are popped. The CORDIC
// stage count and the multiplier stages set the latency.
// When the result queue fills, the back pipeline holds; the front then fills
// its queue and raises full. Reset empties both queues and all pipelines.
// ----------------------------------------------------------------------------
module euler_zyx_vector_rotate #(
  parameter int CORDIC_STEPS = evr_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  evr_pkg::in_t  item,
  output logic          full,
  input  logic          pop,
  output evr_pkg::out_t result,
  output logic          empty
);

  logic           mid_full, mid_empty, mid_push, mid_pop;
  logic           front_en, back_en, front_valid, back_valid, out_full;
  evr_pkg::work_t front_work, mid_work;
  evr_pkg::out_t  back_res;

  assign front_en = !mid_full;
  assign full     = mid_full;
  assign mid_push = front_valid && front_en;
  assign back_en  = !out_full;
  assign mid_pop  = back_en && !mid_empty;

  evr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (front_en),
    .load      (push),
    .item      (item),
    .out_valid (front_valid),
    .out_work  (front_work)
  );

  evr_fifo #(.T(evr_pkg::work_t), .DEPTH(evr_pkg::MID_DEPTH)) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .din   (front_work),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_work),
    .empty (mid_empty)
  );

  evr_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (back_en),
    .load      (mid_pop),
    .work      (mid_work),
    .res_valid (back_valid),
    .res       (back_res)
  );

  evr_fifo #(.T(evr_pkg::out_t), .DEPTH(evr_pkg::OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (back_valid && back_en),
    .din   (back_res),
    .full  (out_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

// ===== test/tb_euler_zyx_vector_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_zyx_vector_rotate
// Random and directed test of the Euler ZYX vector rotator.
// ----------------------------------------------------------------------------
// Requests carry a vector, an accumulator and roll, pitch and yaw angles. A
// predictor builds the rotation from its own CORDIC and forms the expected saturated
// sum for each request. Results are compared field by field in order, with random
// input bursts, random stalls on the output side, one long output stall and a full
// drain after each test.
// ----------------------------------------------------------------------------
module tb_euler_zyx_vector_rotate;

  localparam int  STEPS     = evr_pkg::CORDIC_STEPS_DEF;
  localparam int  LATENCY   = STEPS + 11;
  localparam longint LIMIT  = 400000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          push = 1'b0;
  evr_pkg::in_t  item = '0;
  logic          full;
  logic          pop = 1'b0;
  evr_pkg::out_t result;
  logic          empty;

  evr_pkg::out_t expected_q[$];
  int     errors = 0;
  int     results_seen = 0;
  int     requests_sent = 0;
  longint cycle = 0;
  int     hold_cycles = 0;
  bit     random_pop = 1'b0;

  euler_zyx_vector_rotate #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .pop(pop), .result(result), .empty(empty)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint turn_atan(int i);
    case (i)
      0:  return 536870912;  1:  return 316933406;  2:  return 167458907;
      3:  return 85004756;   4:  return 42667331;   5:  return 21354465;
      6:  return 10679838;   7:  return 5340245;    8:  return 2670163;
      9:  return 1335087;    10: return 667544;     11: return 333772;
      12: return 166886;     13: return 83443;      14: return 41722;
      15: return 20861;      16: return 10430;      17: return 5215;
      18: return 2608;       19: return 1304;       20: return 652;
      21: return 326;        22: return 163;        default: return 81;
    endcase
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic void angle_sin_cos(input logic signed [15:0] ang,
                                        output longint sn, output longint cs);
    longint r, x, y, z, dx, dy;
    logic [31:0] ph;
    logic [63:0] wide;
    bit flip;
    r = longint'(ang) % 23040;
    if (r < 0) r += 23040;
    wide = ((64'(r) << 32) + 64'd11520) / 64'd23040;
    ph = wide[31:0];
    flip = ph[31] ^ ph[30];
    if (flip) ph = ph - 32'h8000_0000;
    z = longint'(signed'(ph));
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= turn_atan(i);
      end else begin
        x += dx; y -= dy; z += turn_atan(i);
      end
    end
    cs = unit_clamp(floor_shift(x + 8192, 14));
    sn = unit_clamp(floor_shift(y + 8192, 14));
    if (flip) begin
      cs = -cs; sn = -sn;
    end
  endfunction

  function automatic longint q48_round(longint e);
    return floor_shift(e + (longint'(1) << 31), 32);
  endfunction

  function automatic evr_pkg::out_t rotate_and_add(evr_pkg::in_t a);
    longint sr, cr, sp, cp, sy, cy, s, r;
    longint m[3][3];
    longint v[3], acc[3];
    longint one;
    evr_pkg::out_t o;
    one = 65536;
    v = '{a.vec_x, a.vec_y, a.vec_z};
    acc = '{a.acc_x, a.acc_y, a.acc_z};
    angle_sin_cos(a.roll_angle, sr, cr);
    angle_sin_cos(a.pitch_angle, sp, cp);
    angle_sin_cos(a.yaw_angle, sy, cy);
    m[0][0] = q48_round(cy * cp * one);
    m[0][1] = q48_round(cy * sp * sr - sy * cr * one);
    m[0][2] = q48_round(cy * sp * cr + sy * sr * one);
    m[1][0] = q48_round(sy * cp * one);
    m[1][1] = q48_round(sy * sp * sr + cy * cr * one);
    m[1][2] = q48_round(sy * sp * cr - cy * sr * one);
    m[2][0] = q48_round(-sp * one * one);
    m[2][1] = q48_round(cp * sr * one);
    m[2][2] = q48_round(cp * cr * one);
    for (int k = 0; k < 3; k++) begin
      s = m[k][0] * v[0] + m[k][1] * v[1] + m[k][2] * v[2];
      r = floor_shift(s + 32768, 16) + acc[k];
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      case (k)
        0: o.res_x = r[31:0];
        1: o.res_y = r[31:0];
        default: o.res_z = r[31:0];
      endcase
    end
    return o;
  endfunction

  // Output side: random or patterned stalls, a hold counted down for the long stretch.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else if (random_pop) begin
      pop <= ($urandom_range(0, 3) != 0);
    end else begin
      pop <= ((cycle / 64) % 3 != 0);
    end
  end

  always @(posedge clk) begin
    evr_pkg::out_t exp_r;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with no request waiting");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (result.res_x !== exp_r.res_x) begin
          $error("res_x expected %0d actual %0d", exp_r.res_x, result.res_x);
          errors++;
        end
        if (result.res_y !== exp_r.res_y) begin
          $error("res_y expected %0d actual %0d", exp_r.res_y, result.res_y);
          errors++;
        end
        if (result.res_z !== exp_r.res_z) begin
          $error("res_z expected %0d actual %0d", exp_r.res_z, result.res_z);
          errors++;
        end
      end
    end
  end

  task automatic send_request(input evr_pkg::in_t a);
    push <= 1'b1;
    item <= a;
    do @(posedge clk); while (full);
    expected_q.push_back(rotate_and_add(a));
    requests_sent++;
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] any_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 46080)) - 23040);
      2: return 16'(int'($urandom_range(0, 8)) * 2880 - 11520);
      default: return 16'(int'($urandom_range(0, 46080)) - 23040);
    endcase
  endfunction

  function automatic logic signed [31:0] any_word();
    case ($urandom_range(0, 4))
      0: return 32'($urandom);
      1: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  function automatic evr_pkg::in_t random_request();
    evr_pkg::in_t a;
    a.vec_x = any_word(); a.vec_y = any_word(); a.vec_z = any_word();
    a.acc_x = any_word(); a.acc_y = any_word(); a.acc_z = any_word();
    a.roll_angle = any_angle();
    a.pitch_angle = any_angle();
    a.yaw_angle = any_angle();
    return a;
  endfunction

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    evr_pkg::in_t a;
    logic signed [15:0] angles[12];
    angles = '{16'sd0, 16'sd5760, 16'sd11520, 16'sd17280, 16'sd23040, -16'sd23040,
               -16'sd5760, 16'sd23041, 16'sh7fff, 16'sh8000, 16'sd1, -16'sd1};
    for (int i = 0; i < 12; i++) begin
      a = '{32'sh10000, 32'sh20000, -32'sh30000, 32'sd0, 32'sd5, -32'sd5,
            angles[i], angles[(i + 3) % 12], angles[(i + 7) % 12]};
      send_request(a);
    end
    a = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sd0, 16'sd0, 16'sd0};
    send_request(a);
    a = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sd0, 16'sd0, 16'sd0};
    send_request(a);
    a = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
          32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sd2880, 16'sd8000, -16'sd3000};
    send_request(a);
    a = '{32'hffffffff, 32'h0, 32'hffffffff, 32'h0, 32'hffffffff, 32'h0,
          16'hffff, 16'h0, 16'hffff};
    send_request(a);
    a = '{32'h0, 32'hffffffff, 32'h0, 32'hffffffff, 32'h0, 32'hffffffff,
          16'h0, 16'hffff, 16'h0};
    send_request(a);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    random_pop = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_request(random_request());
      idle_gap();
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles <= 200;
    for (int i = 0; i < 60; i++) send_request(random_request());
    wait_drained();
  endtask

  task automatic test_patterned(input int count);
    random_pop = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_request(random_request());
      if (i % 100 > 60) idle_gap();
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_backpressure();
    test_patterned(570);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d requests, checked %0d results, including extreme angles,",
             requests_sent, results_seen);
    $display("saturation cases and a long output stall.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== euler_zyx_vector_rotate.f =====
hdl/evr_pkg.sv
hdl/evr_fifo.sv
hdl/evr_front.sv
hdl/evr_back.sv
hdl/euler_zyx_vector_rotate.sv
test/tb_euler_zyx_vector_rotate.sv
